// ----- sv/spc_pkg.sv -----
// shared types, constants and rounding helpers for the sphere pair collision response block
// no dependencies
package spc_pkg;

  localparam int COORD_W  = 24;
  localparam int SHIFT_W  = 17;
  localparam int FRAC_W   = 12;
  localparam int CFG_W    = 16;
  localparam int SEP_W    = 13;
  localparam int MAG_W    = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int NORM_W   = FRAC_W + 2;

  localparam logic [1:0] OUT_APART     = 2'd0;
  localparam logic [1:0] OUT_COINCIDE  = 2'd1;
  localparam logic [1:0] OUT_SEPARATE  = 2'd2;
  localparam logic [1:0] OUT_RESOLVED  = 2'd3;

  localparam logic [1:0] REG_CONTACT   = 2'd0;
  localparam logic [1:0] REG_REST      = 2'd1;
  localparam logic [1:0] REG_IMP_GAIN  = 2'd2;
  localparam logic [1:0] REG_SEP_GAIN  = 2'd3;

  localparam logic [CFG_W-1:0] CONTACT_RST  = 16'd12288;
  localparam logic [CFG_W-1:0] REST_RST     = 16'd16384;
  localparam logic [CFG_W-1:0] IMP_GAIN_RST = 16'd5603;
  localparam logic [SEP_W-1:0] SEP_GAIN_RST = 13'd2048;

  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint SHIFT_MAX = (longint'(1) << (SHIFT_W - 1)) - 1;
  localparam logic [63:0] HALF = 64'd1 << (FRAC_W - 1);

  typedef struct packed {
    logic [CFG_W-1:0]   contact;
    logic [CFG_W-1:0]   rest;
    logic [CFG_W-1:0]   imp_gain;
    logic [SEP_W-1:0]   sep_gain;
    logic [2*CFG_W-1:0] contact_sq;
    logic [2*CFG_W-1:0] rest_sq;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                neg;
    logic [2:0][MAG_W-1:0]     mag;
    logic [2:0][DIFF_W-1:0]    rv;
    logic                      apart;
    logic                      coin;
    logic                      rest;
    logic [2*MAG_W-1:0]        dist2;
    logic [MAG_W-1:0]          cdist;
    logic [2:0][NORM_W-1:0]    n;
  } pipe_t;

  // round to nearest, ties away from zero, drop the fraction bits
  function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
    logic [63:0] mg;
    logic [63:0] r;
    mg = v[63] ? (64'd0 - v) : v;
    r  = (mg + HALF) >> FRAC_W;
    return v[63] ? $signed(64'd0 - r) : $signed(r);
  endfunction

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    else if (v < -COORD_MAX - 1) return COORD_W'(-COORD_MAX - 1);
    else return v[COORD_W-1:0];
  endfunction

  function automatic logic [SHIFT_W-1:0] sat_shift(input logic signed [63:0] v);
    if (v > SHIFT_MAX) return SHIFT_W'(SHIFT_MAX);
    else if (v < -SHIFT_MAX - 1) return SHIFT_W'(-SHIFT_MAX - 1);
    else return v[SHIFT_W-1:0];
  endfunction

endpackage

// ----- sv/spc_if.sv -----
// request channels: sphere pair in, collision response out
// depends on spc_pkg
interface spc_pair_if;
  logic valid;
  logic ready;
  logic signed [spc_pkg::COORD_W-1:0] first_pos_x;
  logic signed [spc_pkg::COORD_W-1:0] first_pos_y;
  logic signed [spc_pkg::COORD_W-1:0] first_pos_z;
  logic signed [spc_pkg::COORD_W-1:0] second_pos_x;
  logic signed [spc_pkg::COORD_W-1:0] second_pos_y;
  logic signed [spc_pkg::COORD_W-1:0] second_pos_z;
  logic signed [spc_pkg::COORD_W-1:0] first_vel_x;
  logic signed [spc_pkg::COORD_W-1:0] first_vel_y;
  logic signed [spc_pkg::COORD_W-1:0] first_vel_z;
  logic signed [spc_pkg::COORD_W-1:0] second_vel_x;
  logic signed [spc_pkg::COORD_W-1:0] second_vel_y;
  logic signed [spc_pkg::COORD_W-1:0] second_vel_z;

  modport source (output valid, first_pos_x, first_pos_y, first_pos_z, second_pos_x,
                  second_pos_y, second_pos_z, first_vel_x, first_vel_y, first_vel_z,
                  second_vel_x, second_vel_y, second_vel_z, input ready);
  modport sink (input valid, first_pos_x, first_pos_y, first_pos_z, second_pos_x,
                second_pos_y, second_pos_z, first_vel_x, first_vel_y, first_vel_z,
                second_vel_x, second_vel_y, second_vel_z, output ready);
endinterface

interface spc_result_if;
  logic valid;
  logic ready;
  logic signed [spc_pkg::COORD_W-1:0] impulse_x;
  logic signed [spc_pkg::COORD_W-1:0] impulse_y;
  logic signed [spc_pkg::COORD_W-1:0] impulse_z;
  logic signed [spc_pkg::SHIFT_W-1:0] shift_x;
  logic signed [spc_pkg::SHIFT_W-1:0] shift_y;
  logic signed [spc_pkg::SHIFT_W-1:0] shift_z;
  logic [1:0] outcome;

  modport source (output valid, impulse_x, impulse_y, impulse_z, shift_x, shift_y,
                  shift_z, outcome, input ready);
  modport sink (input valid, impulse_x, impulse_y, impulse_z, shift_x, shift_y,
                shift_z, outcome, output ready);
endinterface

// ----- sv/spc_front.sv -----
// front stages: centre offset, squared distance, contact and rest tests
// depends on spc_pkg
module spc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [spc_pkg::COORD_W-1:0]  fp_i [3],
  input  logic signed [spc_pkg::COORD_W-1:0]  sp_i [3],
  input  logic signed [spc_pkg::COORD_W-1:0]  fv_i [3],
  input  logic signed [spc_pkg::COORD_W-1:0]  sv_i [3],
  input  spc_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  output spc_pkg::pipe_t                      pipe_o
);

  localparam int DW = spc_pkg::DIFF_W;
  localparam int MW = spc_pkg::MAG_W;

  logic                v1_q, v2_q, v3_q;
  logic [DW-1:0]       d1_d [3], d1_q [3];
  logic [2:0][DW-1:0]  rv1_d, rv1_q, rv2_q;
  logic [2:0]          neg2_d, neg2_q, big2_d, big2_q;
  logic [2:0][MW-1:0]  mag2_d, mag2_q;
  logic [2*MW-1:0]     sq2_d [3], sq2_q [3];
  spc_pkg::pipe_t      p3_d, p3_q;
  logic [2*MW+1:0]     sum;
  logic [DW-1:0]       dm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_d[i]  = DW'(sp_i[i]) - DW'(fp_i[i]);
      rv1_d[i] = DW'(fv_i[i]) - DW'(sv_i[i]);
    end
  end

  always_comb begin
    dm = '0;
    for (int i = 0; i < 3; i++) begin
      dm        = d1_q[i][DW-1] ? (DW'(0) - d1_q[i]) : d1_q[i];
      neg2_d[i] = d1_q[i][DW-1];
      big2_d[i] = |dm[DW-1:MW];
      mag2_d[i] = dm[MW-1:0];
      sq2_d[i]  = dm[MW-1:0] * dm[MW-1:0];
    end
  end

  always_comb begin
    sum          = (2*MW+2)'(sq2_q[0]) + (2*MW+2)'(sq2_q[1]) + (2*MW+2)'(sq2_q[2]);
    p3_d         = '0;
    p3_d.neg     = neg2_q;
    p3_d.mag     = mag2_q;
    p3_d.rv      = rv2_q;
    // any axis offset of 2^16 or more is past every contact distance
    p3_d.apart   = (|big2_q) || (sum > (2*MW+2)'(cfg_i.contact_sq));
    p3_d.coin    = (sum == '0);
    p3_d.rest    = sum < (2*MW+2)'(cfg_i.rest_sq);
    p3_d.dist2   = sum[2*MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q   <= d1_d;
      rv1_q  <= rv1_d;
      rv2_q  <= rv1_q;
      neg2_q <= neg2_d;
      big2_q <= big2_d;
      mag2_q <= mag2_d;
      sq2_q  <= sq2_d;
      p3_q   <= p3_d;
    end
  end

  assign valid_o = v3_q;
  assign pipe_o  = p3_q;

endmodule

// ----- sv/spc_sqrt.sv -----
// pipelined integer square root of the squared centre distance, one root bit per step
// depends on spc_pkg
module spc_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  spc_pkg::pipe_t pipe_i,
  output logic           valid_o,
  output spc_pkg::pipe_t pipe_o
);

  localparam int MW     = spc_pkg::MAG_W;
  localparam int STEPS  = 4;
  localparam int NST    = MW / STEPS;
  localparam int RW     = MW + 2;

  logic                v_q [NST];
  spc_pkg::pipe_t      p_q [NST];
  logic [RW-1:0]       rem_d [NST], rem_q [NST];
  logic [MW-1:0]       root_d [NST], root_q [NST];
  logic [2*MW-1:0]     x_d [NST], x_q [NST];

  always_comb begin
    logic [RW-1:0]   rem;
    logic [MW-1:0]   root;
    logic [2*MW-1:0] x;
    logic [RW+1:0]   trial;
    logic [RW+1:0]   cand;
    for (int s = 0; s < NST; s++) begin
      rem  = (s == 0) ? '0 : rem_q[(s == 0) ? 0 : s-1];
      root = (s == 0) ? '0 : root_q[(s == 0) ? 0 : s-1];
      x    = (s == 0) ? pipe_i.dist2 : x_q[(s == 0) ? 0 : s-1];
      for (int j = 0; j < STEPS; j++) begin
        trial = {rem, x[2*MW-1 -: 2]};
        cand  = {2'b00, root, 2'b01};
        if (trial >= cand) begin
          rem  = RW'(trial - cand);
          root = {root[MW-2:0], 1'b1};
        end else begin
          rem  = trial[RW-1:0];
          root = {root[MW-2:0], 1'b0};
        end
        x = {x[2*MW-3:0], 2'b00};
      end
      rem_d[s]  = rem;
      root_d[s] = root;
      x_d[s]    = x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < NST; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= pipe_i;
      for (int s = 1; s < NST; s++) p_q[s] <= p_q[s-1];
      rem_q  <= rem_d;
      root_q <= root_d;
      x_q    <= x_d;
    end
  end

  always_comb begin
    pipe_o       = p_q[NST-1];
    pipe_o.cdist = root_q[NST-1];
  end
  assign valid_o = v_q[NST-1];

endmodule

// ----- sv/spc_div.sv -----
// pipelined restoring divider: rounded unit normal per axis, offset times 2^12 over distance
// depends on spc_pkg
module spc_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  spc_pkg::pipe_t pipe_i,
  output logic           valid_o,
  output spc_pkg::pipe_t pipe_o
);

  localparam int MW    = spc_pkg::MAG_W;
  localparam int FW    = spc_pkg::FRAC_W;
  localparam int NW    = spc_pkg::NORM_W;
  localparam int QB    = FW + 1;
  localparam int STEPS = 4;
  localparam int NST   = (QB + STEPS - 1) / STEPS;
  localparam int RW    = MW + FW + 1;

  logic                v_q [NST];
  spc_pkg::pipe_t      p_q [NST];
  logic [RW-1:0]       rem_d [NST][3], rem_q [NST][3];
  logic [QB-1:0]       q_d [NST][3], q_q [NST][3];

  always_comb begin
    logic [RW-1:0] rem;
    logic [QB-1:0] q;
    logic [RW-1:0] dv;
    logic [MW-1:0] cdist;
    for (int s = 0; s < NST; s++) begin
      cdist = (s == 0) ? pipe_i.cdist : p_q[(s == 0) ? 0 : s-1].cdist;
      for (int i = 0; i < 3; i++) begin
        if (s == 0) begin
          // numerator carries half the divisor so the quotient comes out rounded
          rem = RW'({pipe_i.mag[i], FW'(0)}) + RW'(cdist[MW-1:1]);
          q   = '0;
        end else begin
          rem = rem_q[(s == 0) ? 0 : s-1][i];
          q   = q_q[(s == 0) ? 0 : s-1][i];
        end
        for (int j = 0; j < STEPS; j++) begin
          if (QB - 1 - (s * STEPS + j) >= 0) begin
            dv = RW'(cdist) << (QB - 1 - (s * STEPS + j));
            if (rem >= dv) begin
              rem = rem - dv;
              q   = {q[QB-2:0], 1'b1};
            end else begin
              q   = {q[QB-2:0], 1'b0};
            end
          end
        end
        rem_d[s][i] = rem;
        q_d[s][i]   = q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < NST; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= pipe_i;
      for (int s = 1; s < NST; s++) p_q[s] <= p_q[s-1];
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  always_comb begin
    pipe_o = p_q[NST-1];
    for (int i = 0; i < 3; i++) begin
      pipe_o.n[i] = p_q[NST-1].neg[i] ? (NW'(0) - NW'(q_q[NST-1][i])) : NW'(q_q[NST-1][i]);
    end
  end
  assign valid_o = v_q[NST-1];

endmodule

// ----- sv/spc_resp.sv -----
// response stages: normal velocity, impulse and separation scaling, output register
// depends on spc_pkg
module spc_resp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  spc_pkg::pipe_t                      pipe_i,
  input  spc_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  output logic signed [spc_pkg::COORD_W-1:0]  imp_o [3],
  output logic signed [spc_pkg::SHIFT_W-1:0]  shift_o [3],
  output logic [1:0]                          outcome_o
);

  localparam int NW = spc_pkg::NORM_W;
  localparam int DW = spc_pkg::DIFF_W;
  localparam int CW = spc_pkg::COORD_W;
  localparam int SW = spc_pkg::SHIFT_W;
  localparam int PW = DW + NW;        // velocity times normal
  localparam int VW = PW + 2;         // sum of three
  localparam int AW = VW - spc_pkg::FRAC_W;
  localparam int GW = spc_pkg::CFG_W + 1;
  localparam int XW = AW + 1 + GW;    // negated normal speed times gain
  localparam int SSW = XW - spc_pkg::FRAC_W;
  localparam int IW = SSW + NW;
  localparam int OW = spc_pkg::CFG_W + 1;
  localparam int QW = OW + spc_pkg::SEP_W + 1;
  localparam int MSW = QW - spc_pkg::FRAC_W;
  localparam int HW = MSW + NW;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // stage 1
  logic signed [PW-1:0]  prod1_d [3], prod1_q [3];
  logic signed [QW-1:0]  pv1_d, pv1_q;
  logic signed [OW-1:0]  ov;
  logic [2:0][NW-1:0]    n1_q, n2_q, n3_q, n4_q;
  logic                  apart1_q, coin1_q, rest1_q, rest2_q, rest3_q;

  // stage 2
  logic signed [VW-1:0]  vs;
  logic signed [AW-1:0]  van2_d, van2_q;
  logic signed [MSW-1:0] m2_d, m2_q;
  logic [1:0]            code2_d, code2_q, code3_q, code4_q, code5_q;

  // stage 3
  logic signed [XW-1:0]  sp3_d, sp3_q;
  logic signed [HW-1:0]  shp3_d [3], shp3_q [3];

  // stage 4
  logic signed [SSW-1:0] s4_d, s4_q;
  logic [SW-1:0]         sh4_d [3], sh4_q [3], sh5_q [3];

  // stage 5 and output
  logic signed [IW-1:0]  ip5_d [3], ip5_q [3];
  logic [CW-1:0]         imp6_d [3], imp6_q [3];
  logic [SW-1:0]         sh6_q [3];
  logic [1:0]            code6_q;

  always_comb begin
    ov = OW'(cfg_i.rest) - OW'(pipe_i.cdist);
    pv1_d = QW'(ov) * QW'($signed({1'b0, cfg_i.sep_gain}));
    for (int i = 0; i < 3; i++) begin
      prod1_d[i] = PW'($signed(pipe_i.rv[i])) * PW'($signed(pipe_i.n[i]));
    end
  end

  always_comb begin
    vs     = VW'(prod1_q[0]) + VW'(prod1_q[1]) + VW'(prod1_q[2]);
    van2_d = AW'(spc_pkg::rnd_frac(64'(vs)));
    m2_d   = MSW'(spc_pkg::rnd_frac(64'(pv1_q)));
    if (apart1_q) code2_d = spc_pkg::OUT_APART;
    else if (coin1_q) code2_d = spc_pkg::OUT_COINCIDE;
    else if (!vs[VW-1] && (vs != '0)) code2_d = spc_pkg::OUT_SEPARATE;
    else code2_d = spc_pkg::OUT_RESOLVED;
  end

  always_comb begin
    sp3_d = (XW'(0) - XW'(van2_q)) * XW'($signed({1'b0, cfg_i.imp_gain}));
    for (int i = 0; i < 3; i++) begin
      shp3_d[i] = HW'(m2_q) * HW'($signed(n2_q[i]));
    end
  end

  always_comb begin
    s4_d = SSW'(spc_pkg::rnd_frac(64'(sp3_q)));
    for (int i = 0; i < 3; i++) begin
      sh4_d[i] = (rest3_q && code3_q == spc_pkg::OUT_RESOLVED)
               ? spc_pkg::sat_shift(spc_pkg::rnd_frac(64'(shp3_q[i]))) : '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ip5_d[i]  = IW'(s4_q) * IW'($signed(n4_q[i]));
      imp6_d[i] = (code5_q == spc_pkg::OUT_RESOLVED)
                ? spc_pkg::sat_coord(spc_pkg::rnd_frac(64'(ip5_q[i]))) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q  <= prod1_d;
      pv1_q    <= pv1_d;
      n1_q     <= pipe_i.n;
      apart1_q <= pipe_i.apart;
      coin1_q  <= pipe_i.coin;
      rest1_q  <= pipe_i.rest;
      van2_q   <= van2_d;
      m2_q     <= m2_d;
      code2_q  <= code2_d;
      n2_q     <= n1_q;
      rest2_q  <= rest1_q;
      sp3_q    <= sp3_d;
      shp3_q   <= shp3_d;
      code3_q  <= code2_q;
      n3_q     <= n2_q;
      rest3_q  <= rest2_q;
      s4_q     <= s4_d;
      sh4_q    <= sh4_d;
      code4_q  <= code3_q;
      n4_q     <= n3_q;
      ip5_q    <= ip5_d;
      sh5_q    <= sh4_q;
      code5_q  <= code4_q;
      imp6_q   <= imp6_d;
      sh6_q    <= sh5_q;
      code6_q  <= code5_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      imp_o[i]   = $signed(imp6_q[i]);
      shift_o[i] = $signed(sh6_q[i]);
    end
  end
  assign valid_o   = v6_q;
  assign outcome_o = code6_q;

endmodule

// ----- sv/sphere_pair_collision_response.sv -----
// pipeline: 3 front, 4 square root, 4 divider and 6 response stages from an accepted pair
// request to its result, the last one the output register
// throughput: one pair per cycle; the whole pipeline advances whenever the output register
// is empty or being taken, so a stalled result holds every stage in place
// reset: valid bits clear and the configuration registers load their defaults
// top level; depends on spc_pkg, spc_if, spc_front, spc_sqrt, spc_div, spc_resp
module sphere_pair_collision_response (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [spc_pkg::CFG_W-1:0]   cfg_data_i,
  spc_pair_if.sink                    pair_i,
  spc_result_if.source                result_o
);

  logic [spc_pkg::CFG_W-1:0]   contact_q, rest_q, imp_gain_q;
  logic [spc_pkg::SEP_W-1:0]   sep_gain_q;
  logic [2*spc_pkg::CFG_W-1:0] contact_sq_q, rest_sq_q;
  spc_pkg::cfg_t               cfg;

  logic                                en;
  logic signed [spc_pkg::COORD_W-1:0]  fp [3], sp [3], fv [3], sv [3];
  logic                                fr_valid, sq_valid, dv_valid;
  spc_pkg::pipe_t                      fr_pipe, sq_pipe, dv_pipe;
  logic signed [spc_pkg::COORD_W-1:0]  imp [3];
  logic signed [spc_pkg::SHIFT_W-1:0]  shift [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_q    <= spc_pkg::CONTACT_RST;
      rest_q       <= spc_pkg::REST_RST;
      imp_gain_q   <= spc_pkg::IMP_GAIN_RST;
      sep_gain_q   <= spc_pkg::SEP_GAIN_RST;
      contact_sq_q <= spc_pkg::CONTACT_RST * spc_pkg::CONTACT_RST;
      rest_sq_q    <= spc_pkg::REST_RST * spc_pkg::REST_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spc_pkg::REG_CONTACT:  contact_q  <= cfg_data_i;
          spc_pkg::REG_REST:     rest_q     <= cfg_data_i;
          spc_pkg::REG_IMP_GAIN: imp_gain_q <= cfg_data_i;
          spc_pkg::REG_SEP_GAIN: sep_gain_q <= cfg_data_i[spc_pkg::SEP_W-1:0];
          default: ;
        endcase
      end
      // squares are registered from the stored values and follow a write in the next cycle
      contact_sq_q <= contact_q * contact_q;
      rest_sq_q    <= rest_q * rest_q;
    end
  end

  always_comb begin
    cfg.contact    = contact_q;
    cfg.rest       = rest_q;
    cfg.imp_gain   = imp_gain_q;
    cfg.sep_gain   = sep_gain_q;
    cfg.contact_sq = contact_sq_q;
    cfg.rest_sq    = rest_sq_q;
  end

  assign en           = !result_o.valid || result_o.ready;
  assign pair_i.ready = en;

  always_comb begin
    fp[0] = pair_i.first_pos_x;   fp[1] = pair_i.first_pos_y;   fp[2] = pair_i.first_pos_z;
    sp[0] = pair_i.second_pos_x;  sp[1] = pair_i.second_pos_y;  sp[2] = pair_i.second_pos_z;
    fv[0] = pair_i.first_vel_x;   fv[1] = pair_i.first_vel_y;   fv[2] = pair_i.first_vel_z;
    sv[0] = pair_i.second_vel_x;  sv[1] = pair_i.second_vel_y;  sv[2] = pair_i.second_vel_z;
  end

  spc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pair_i.valid),
    .fp_i    (fp),
    .sp_i    (sp),
    .fv_i    (fv),
    .sv_i    (sv),
    .cfg_i   (cfg),
    .valid_o (fr_valid),
    .pipe_o  (fr_pipe)
  );

  spc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .pipe_i  (fr_pipe),
    .valid_o (sq_valid),
    .pipe_o  (sq_pipe)
  );

  spc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .pipe_i  (sq_pipe),
    .valid_o (dv_valid),
    .pipe_o  (dv_pipe)
  );

  spc_resp u_resp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (dv_valid),
    .pipe_i    (dv_pipe),
    .cfg_i     (cfg),
    .valid_o   (result_o.valid),
    .imp_o     (imp),
    .shift_o   (shift),
    .outcome_o (result_o.outcome)
  );

  assign result_o.impulse_x = imp[0];
  assign result_o.impulse_y = imp[1];
  assign result_o.impulse_z = imp[2];
  assign result_o.shift_x   = shift[0];
  assign result_o.shift_y   = shift[1];
  assign result_o.shift_z   = shift[2];

endmodule

// ----- tb/sv/sphere_pair_collision_response_tb.sv -----
// self-checking testbench for the sphere pair collision response block
// streams sphere pairs through a queue-fed driver and checks every response against a predictor
// depends on spc_pkg, spc_if and the sphere_pair_collision_response rtl
`timescale 1ns / 1ps

module sphere_pair_collision_response_tb;

  localparam int CW = spc_pkg::COORD_W;
  localparam int SW = spc_pkg::SHIFT_W;
  localparam int FW = spc_pkg::FRAC_W;
  localparam int GW = spc_pkg::CFG_W;

  typedef struct {
    logic signed [CW-1:0] p1[3];
    logic signed [CW-1:0] p2[3];
    logic signed [CW-1:0] v1[3];
    logic signed [CW-1:0] v2[3];
  } pair_t;

  typedef struct {
    logic signed [CW-1:0] imp[3];
    logic signed [SW-1:0] sh[3];
    logic [1:0]           outcome;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = spc_pkg::REG_CONTACT;
  logic [GW-1:0] cfg_data_i = '0;

  spc_pair_if   pair_bus();
  spc_result_if resp_bus();

  sphere_pair_collision_response DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .pair_i(pair_bus.sink), .result_o(resp_bus.source)
  );

  always #5 clk_i = ~clk_i;

  // mirror of the configuration registers
  longint unsigned contact_d = spc_pkg::CONTACT_RST;
  longint unsigned rest_d    = spc_pkg::REST_RST;
  longint unsigned imp_gain  = spc_pkg::IMP_GAIN_RST;
  longint unsigned sep_gain  = spc_pkg::SEP_GAIN_RST;

  pair_t pending_pairs[$];
  resp_t expected_resps[$];
  pair_t cur_pair;
  int mismatches = 0;
  int resp_count = 0;
  int outcome_hits[4] = '{0, 0, 0, 0};
  int send_gap = 0;
  int take_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;

  function automatic longint round_frac(longint v);
    if (v < 0) return -((-v + 2048) >>> FW);
    return (v + 2048) >>> FW;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic resp_t predict_response(pair_t p);
    resp_t r;
    longint d[3], rv[3], nrm[3], imp[3], sh[3];
    longint unsigned dist2, cdist, mg, q;
    longint vs, van, s, m;
    dist2 = 0;
    vs = 0;
    for (int i = 0; i < 3; i++) begin
      d[i]   = longint'(p.p2[i]) - longint'(p.p1[i]);
      rv[i]  = longint'(p.v1[i]) - longint'(p.v2[i]);
      mg     = d[i] < 0 ? -d[i] : d[i];
      dist2 += mg * mg;
      imp[i] = 0;
      sh[i]  = 0;
    end
    if (dist2 > contact_d * contact_d) begin
      r.outcome = spc_pkg::OUT_APART;
    end else if (dist2 == 0) begin
      r.outcome = spc_pkg::OUT_COINCIDE;
    end else begin
      cdist = floor_sqrt(dist2);
      for (int i = 0; i < 3; i++) begin
        mg = d[i] < 0 ? -d[i] : d[i];
        q = ((mg << FW) + (cdist >> 1)) / cdist;
        nrm[i] = d[i] < 0 ? -longint'(q) : longint'(q);
        vs += rv[i] * nrm[i];
      end
      if (vs > 0) begin
        r.outcome = spc_pkg::OUT_SEPARATE;
      end else begin
        r.outcome = spc_pkg::OUT_RESOLVED;
        van = round_frac(vs);
        s = round_frac(-van * longint'(imp_gain));
        for (int i = 0; i < 3; i++) imp[i] = round_frac(s * nrm[i]);
        if (dist2 < rest_d * rest_d) begin
          m = round_frac((longint'(rest_d) - longint'(cdist)) * longint'(sep_gain));
          for (int i = 0; i < 3; i++) sh[i] = round_frac(m * nrm[i]);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.imp[i] = CW'(clip(imp[i], CW));
      r.sh[i]  = SW'(clip(sh[i], SW));
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    logic [31:0] w;
    w = $urandom;
    return w[CW-1:0];
  endfunction

  function automatic longint rand_signed(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // pair with a given centre offset and relative velocity; second sphere at rest
  function automatic pair_t close_pair(longint ox, longint oy, longint oz,
                                       longint rx, longint ry, longint rz);
    pair_t p;
    longint off[3], rv[3], base;
    off = '{ox, oy, oz};
    rv  = '{rx, ry, rz};
    for (int i = 0; i < 3; i++) begin
      base = rand_signed(64'd8000000);
      p.p1[i] = CW'(base);
      p.p2[i] = CW'(base + off[i]);
      p.v1[i] = CW'(rv[i]);
      p.v2[i] = '0;
    end
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    longint span, vspan, base;
    if ($urandom_range(0, 9) == 0) begin
      // noise over the whole field range
      for (int i = 0; i < 3; i++) begin
        p.p1[i] = rand_coord(); p.p2[i] = rand_coord();
        p.v1[i] = rand_coord(); p.v2[i] = rand_coord();
      end
      return p;
    end
    case ($urandom_range(0, 3))
      0: span = 3;
      1: span = 8192;
      2: span = 24576;
      default: span = 65535;
    endcase
    vspan = $urandom_range(0, 4) == 0 ? 64'd8388607 : 64'd65536;
    for (int i = 0; i < 3; i++) begin
      base = rand_signed(64'd8200000);
      p.p1[i] = CW'(base);
      p.p2[i] = CW'(base + rand_signed(span));
      p.v1[i] = CW'(rand_signed(vspan));
      p.v2[i] = CW'(rand_signed(vspan));
    end
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || pair_bus.valid || expected_resps.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_regs(logic [GW-1:0] cd, logic [GW-1:0] rd,
                            logic [GW-1:0] ig, logic [GW-1:0] sg);
    logic [1:0] idx[4];
    logic [GW-1:0] val[4];
    idx = '{spc_pkg::REG_CONTACT, spc_pkg::REG_REST, spc_pkg::REG_IMP_GAIN,
            spc_pkg::REG_SEP_GAIN};
    val = '{cd, rd, ig, sg};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    contact_d = cd;
    rest_d    = rd;
    imp_gain  = ig;
    sep_gain  = sg & 16'h1FFF;
    @(negedge clk_i);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      pending_pairs.push_back(random_pair());
      if (pending_pairs.size() > 40) @(negedge clk_i);
    end
    wait_drained();
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_bus.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (pair_bus.valid && pair_bus.ready) expected_resps.push_back(predict_response(cur_pair));
      if (!pair_bus.valid || pair_bus.ready) begin
        if (send_gap != 0) begin
          pair_bus.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          pair_bus.valid <= 1'b0;
          send_gap <= int'($urandom_range(0, 2));
        end else if (pending_pairs.size() != 0) begin
          cur_pair = pending_pairs.pop_front();
          pair_bus.valid <= 1'b1;
          pair_bus.first_pos_x  <= cur_pair.p1[0];
          pair_bus.first_pos_y  <= cur_pair.p1[1];
          pair_bus.first_pos_z  <= cur_pair.p1[2];
          pair_bus.second_pos_x <= cur_pair.p2[0];
          pair_bus.second_pos_y <= cur_pair.p2[1];
          pair_bus.second_pos_z <= cur_pair.p2[2];
          pair_bus.first_vel_x  <= cur_pair.v1[0];
          pair_bus.first_vel_y  <= cur_pair.v1[1];
          pair_bus.first_vel_z  <= cur_pair.v1[2];
          pair_bus.second_vel_x <= cur_pair.v2[0];
          pair_bus.second_vel_y <= cur_pair.v2[1];
          pair_bus.second_vel_z <= cur_pair.v2[2];
        end else begin
          pair_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    resp_t exp_r;
    resp_t got;
    if (!rst_ni) begin
      resp_bus.ready <= 1'b0;
      take_gap <= 0;
      hold_left <= 0;
    end else begin
      if (resp_bus.valid && resp_bus.ready) begin
        got.imp = '{resp_bus.impulse_x, resp_bus.impulse_y, resp_bus.impulse_z};
        got.sh  = '{resp_bus.shift_x, resp_bus.shift_y, resp_bus.shift_z};
        got.outcome = resp_bus.outcome;
        resp_count++;
        if (expected_resps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
        end else begin
          exp_r = expected_resps.pop_front();
          outcome_hits[exp_r.outcome]++;
          if (got.imp != exp_r.imp || got.sh != exp_r.sh || got.outcome != exp_r.outcome) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"response %0d: exp imp %0d %0d %0d sh %0d %0d %0d oc %0d,",
                        " got imp %0d %0d %0d sh %0d %0d %0d oc %0d"},
                       resp_count, exp_r.imp[0], exp_r.imp[1], exp_r.imp[2], exp_r.sh[0],
                       exp_r.sh[1], exp_r.sh[2], exp_r.outcome, got.imp[0], got.imp[1],
                       got.imp[2], got.sh[0], got.sh[1], got.sh[2], got.outcome);
          end
        end
      end
      // one long hold-off so the pipeline fills and backs up the input
      if (!hold_done && resp_count == 120) begin
        hold_done = 1'b1;
        hold_left <= 80;
        resp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        resp_bus.ready <= 1'b0;
      end else if (take_gap != 0) begin
        take_gap <= take_gap - 1;
        resp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        take_gap <= int'($urandom_range(0, 2));
        resp_bus.ready <= 1'b0;
      end else begin
        resp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed requests at reset defaults
    pending_pairs.push_back(close_pair(0, 0, 0, 100, 0, 0));            // coincident centres
    pending_pairs.push_back(close_pair(12288, 0, 0, 4096, 0, 0));       // exactly at contact
    pending_pairs.push_back(close_pair(12289, 0, 0, 4096, 0, 0));       // just beyond contact
    pending_pairs.push_back(close_pair(0, 8192, 0, 0, 4096, 0));        // separating
    pending_pairs.push_back(close_pair(0, 0, 8192, 0, 0, -4096));       // approaching, overlap
    pending_pairs.push_back(close_pair(4096, 4096, 4096, 0, 0, 0));     // zero normal velocity
    pending_pairs.push_back(close_pair(-5000, 3000, -2000, 7000, -9000, 1234));
    pending_pairs.push_back(close_pair(1, 0, 0, -8388608, 0, 0));
    begin
      pair_t p;
      p = close_pair(0, 0, 0, 0, 0, 0);
      p.p1 = '{-24'sd8388608, -24'sd8388608, -24'sd8388608};
      p.p2 = '{24'sd8388607, 24'sd8388607, 24'sd8388607};
      p.v1 = '{24'sd8388607, -24'sd8388608, 24'sd8388607};
      p.v2 = '{-24'sd8388608, 24'sd8388607, -24'sd8388608};
      pending_pairs.push_back(p);
    end
    wait_drained();

    // extremes: wide contact, strong gains, saturating impulse and shift
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pending_pairs.push_back(close_pair(-1, 0, 0, -8388608, 0, 0));
    pending_pairs.push_back(close_pair(0, 2, 0, 0, -8388608, 0));
    pending_pairs.push_back(close_pair(30000, -30000, 20000, -8388608, 8388607, -8388608));
    pending_pairs.push_back(close_pair(65535, 0, 0, 0, 0, 0));
    random_phase(80);

    // all registers zero: only coincident centres can touch
    write_regs(16'd0, 16'd0, 16'd0, 16'd0);
    pending_pairs.push_back(close_pair(0, 0, 0, 5, 5, 5));
    pending_pairs.push_back(close_pair(1, 0, 0, -5, 0, 0));
    random_phase(40);

    write_regs(16'd20000, 16'd30000, 16'd4096, 16'd4096);
    random_phase(120);

    write_regs(GW'($urandom), GW'($urandom), GW'($urandom), GW'($urandom_range(0, 8191)));
    random_phase(100);

    write_regs(spc_pkg::CONTACT_RST, spc_pkg::REST_RST, spc_pkg::IMP_GAIN_RST,
               GW'(spc_pkg::SEP_GAIN_RST));
    quiet = 1'b1;
    random_phase(140);

    repeat (40) @(posedge clk_i);
    $display("sent %0d pairs over six register settings: apart %0d, coincident %0d,",
             resp_count, outcome_hits[0], outcome_hits[1]);
    $display("separating %0d, resolved %0d, with one long output stall", outcome_hits[2],
             outcome_hits[3]);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d responses outstanding", expected_resps.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/spc_pkg.sv
sv/spc_if.sv
sv/spc_front.sv
sv/spc_sqrt.sv
sv/spc_div.sv
sv/spc_resp.sv
sv/sphere_pair_collision_response.sv
tb/sv/sphere_pair_collision_response_tb.sv
